>>> rtl/srrip_pkg.sv
package srrip_pkg;

    // Event codes carried on the input channel.
    typedef enum logic [1:0] {
        KIND_INVALIDATE = 2'd0,
        KIND_HIT        = 2'd1,
        KIND_FILL       = 2'd2,
        KIND_VICTIM     = 2'd3
    } t_kind;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 3;
    localparam logic [CFG_INDEX_W-1:0] CFG_RRPV_BITS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HIT_ZERO  = 2'd1;

    // Configuration reset values.
    localparam logic [2:0] RRPV_BITS_RESET = 3'd2;
    localparam logic       HIT_ZERO_RESET  = 1'b0;

    // Controller states.
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } t_state;

endpackage

>>> rtl/srrip_replacement_policy.sv
// Static RRIP replacement state for a set-associative cache of SETS sets by
// WAYS ways. Each event (invalidate, hit, fill or victim request) is handled
// in two steps: the set's row is read from a single-port-read, single-port-write
// memory first, then compared across all ways and written back, so a new event
// is not accepted until the previous one has been written back. A victim request
// for a set in range gives one transaction on the output channel; other events
// give none. If the previous victim transaction has not yet been taken, the
// write-back of a new victim request waits for it. After reset the memory is
// cleared one row per cycle, over all SETS rows, before the first event is
// accepted; configuration writes are taken at any time.
module srrip_replacement_policy import srrip_pkg::*; #(
    parameter int WAYS             = 8,
    parameter int SETS             = 64,
    parameter int MAX_COUNTER_BITS = 4
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Configuration write channel
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    // Event channel
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [1:0]             i_kind,
    input  logic [5:0]             i_set_index,
    input  logic [2:0]             i_way_index,
    // Victim channel
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [2:0]             o_victim_way,
    output logic                   o_chose_invalid
);

    localparam int CW = MAX_COUNTER_BITS;
    localparam int AW = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int IW = $clog2(WAYS);
    localparam int DW = WAYS * (CW + 1);
    localparam logic [AW-1:0] LAST_SET = AW'(SETS - 1);

    t_state r_state, n_state;

    logic [2:0]    r_rrpv_bits;
    logic          r_hit_zero;
    logic [AW-1:0] r_clr_addr;
    logic [AW-1:0] r_set;
    t_kind         r_kind;
    logic [2:0]    r_way;
    logic          r_active;
    logic          r_out_valid;
    logic [2:0]    r_victim_way;
    logic          r_chose_invalid;

    logic          in_fire;
    logic          exec_stall;
    logic          exec_done;
    logic          set_ok;
    logic          way_ok;
    logic [3:0]    eff_bits;
    logic [CW-1:0] cnt_max;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [DW-1:0] mem_wdata;
    logic [DW-1:0] mem_rdata;

    logic [WAYS*CW-1:0] new_ctr;
    logic [WAYS-1:0]    new_vld;
    logic [IW-1:0]      victim;
    logic               chose_inv;

    // Configuration registers.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rrpv_bits <= RRPV_BITS_RESET;
            r_hit_zero  <= HIT_ZERO_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_RRPV_BITS: r_rrpv_bits <= i_cfg_data;
                CFG_HIT_ZERO:  r_hit_zero  <= i_cfg_data[0];
                default:       r_rrpv_bits <= r_rrpv_bits;
            endcase
        end
    end

    // Counter maximum from the counter width in use, held to 1..MAX_COUNTER_BITS.
    always_comb begin
        if (r_rrpv_bits == '0) begin
            eff_bits = 4'd1;
        end else if ({1'b0, r_rrpv_bits} > 4'(CW)) begin
            eff_bits = 4'(CW);
        end else begin
            eff_bits = {1'b0, r_rrpv_bits};
        end
        for (int i = 0; i < CW; i++) begin
            cnt_max[i] = (i < int'(eff_bits));
        end
    end

    // Events outside the cache geometry are dropped.
    assign set_ok = (SETS >= 64) || (int'(i_set_index) < SETS);
    assign way_ok = (int'(i_way_index) < WAYS);

    // State machine: next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: if (r_clr_addr == LAST_SET) n_state = ST_IDLE;
            ST_IDLE:  if (in_fire) n_state = ST_EXEC;
            ST_EXEC:  if (!exec_stall) n_state = ST_IDLE;
            default:  n_state = ST_CLEAR;
        endcase
    end

    // State machine: outputs.
    always_comb begin
        o_in_ready = 1'b0;
        exec_stall = 1'b0;
        exec_done  = 1'b0;
        unique case (r_state)
            ST_CLEAR: o_in_ready = 1'b0;
            ST_IDLE:  o_in_ready = 1'b1;
            ST_EXEC: begin
                exec_stall = r_active && r_kind == KIND_VICTIM && r_out_valid && !i_out_ready;
                exec_done  = !exec_stall;
            end
            default:  o_in_ready = 1'b0;
        endcase
    end

    assign in_fire = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
        end
    end

    // Capture the accepted event transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (in_fire) begin
            r_active <= set_ok && (t_kind'(i_kind) == KIND_VICTIM || way_ok);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_set  <= AW'(i_set_index);
            r_kind <= t_kind'(i_kind);
            r_way  <= i_way_index;
        end
    end

    // Memory write: clearing sweep, or write-back of the updated row.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_set;
        mem_wdata = {new_vld, new_ctr};
        if (r_state == ST_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_addr;
            mem_wdata = '0;
        end else if (exec_done && r_active) begin
            mem_we = 1'b1;
        end
    end

    srrip_row_mem #(
        .DEPTH (SETS),
        .AW    (AW),
        .DW    (DW)
    ) u_row_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (in_fire),
        .i_raddr (AW'(i_set_index)),
        .o_rdata (mem_rdata)
    );

    srrip_row_logic #(
        .WAYS (WAYS),
        .CW   (CW),
        .IW   (IW)
    ) u_row_logic (
        .i_ctr           (mem_rdata[WAYS*CW-1:0]),
        .i_vld           (mem_rdata[DW-1:WAYS*CW]),
        .i_kind          (r_kind),
        .i_way           (r_way),
        .i_max           (cnt_max),
        .i_hit_zero      (r_hit_zero),
        .o_ctr           (new_ctr),
        .o_vld           (new_vld),
        .o_victim        (victim),
        .o_chose_invalid (chose_inv)
    );

    // Output register for victim transactions.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (exec_done && r_active && r_kind == KIND_VICTIM) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec_done && r_active && r_kind == KIND_VICTIM) begin
            r_victim_way    <= 3'(victim);
            r_chose_invalid <= chose_inv;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_victim_way    = r_victim_way;
    assign o_chose_invalid = r_chose_invalid;

endmodule

>>> rtl/srrip_row_mem.sv
module srrip_row_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int DW    = 40
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    // One row per set: valid bits above the packed counters.
    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/srrip_row_logic.sv
module srrip_row_logic import srrip_pkg::*; #(
    parameter int WAYS = 8,
    parameter int CW   = 4,
    parameter int IW   = 3
) (
    input  logic [WAYS*CW-1:0] i_ctr,
    input  logic [WAYS-1:0]    i_vld,
    input  t_kind              i_kind,
    input  logic [2:0]         i_way,
    input  logic [CW-1:0]      i_max,
    input  logic               i_hit_zero,
    output logic [WAYS*CW-1:0] o_ctr,
    output logic [WAYS-1:0]    o_vld,
    output logic [IW-1:0]      o_victim,
    output logic               o_chose_invalid
);

    logic [CW-1:0]   cur [WAYS];
    logic [WAYS-1:0] first_inv;
    logic [WAYS-1:0] top_sel;
    logic            any_inv;
    logic [CW-1:0]   best_val;
    logic [CW-1:0]   diff;

    // Every counter read sees the stored value limited to the current maximum.
    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            cur[w] = (i_ctr[w*CW +: CW] > i_max) ? i_max : i_ctr[w*CW +: CW];
        end
    end

    // Lowest-numbered invalid way.
    always_comb begin
        logic seen;
        seen = 1'b0;
        for (int w = 0; w < WAYS; w++) begin
            first_inv[w] = !i_vld[w] && !seen;
            seen         = seen || !i_vld[w];
        end
        any_inv = seen;
    end

    // A way is the pick when it beats every lower way and no higher way beats it.
    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            top_sel[w] = 1'b1;
            for (int j = 0; j < WAYS; j++) begin
                if (j < w && cur[j] >= cur[w]) begin
                    top_sel[w] = 1'b0;
                end
                if (j > w && cur[j] > cur[w]) begin
                    top_sel[w] = 1'b0;
                end
            end
        end
    end

    // Encode the chosen way (lowest invalid way if any) and the top counter value.
    always_comb begin
        o_victim = '0;
        best_val = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (top_sel[w]) begin
                best_val = best_val | cur[w];
            end
            if (any_inv ? first_inv[w] : top_sel[w]) begin
                o_victim = o_victim | IW'(w);
            end
        end
        o_chose_invalid = any_inv;
        diff            = i_max - best_val;
    end

    // Build the row that goes back into memory.
    always_comb begin
        logic [CW:0] sum;
        sum   = '0;
        o_ctr = i_ctr;
        o_vld = i_vld;
        unique case (i_kind)
            KIND_INVALIDATE: begin
                for (int w = 0; w < WAYS; w++) begin
                    if (int'(i_way) == w) begin
                        o_vld[w] = 1'b0;
                    end
                end
            end
            KIND_HIT: begin
                for (int w = 0; w < WAYS; w++) begin
                    if (int'(i_way) == w) begin
                        if (i_hit_zero || cur[w] == '0) begin
                            o_ctr[w*CW +: CW] = '0;
                        end else begin
                            o_ctr[w*CW +: CW] = cur[w] - CW'(1);
                        end
                    end
                end
            end
            KIND_FILL: begin
                for (int w = 0; w < WAYS; w++) begin
                    if (int'(i_way) == w) begin
                        o_ctr[w*CW +: CW] = i_max - CW'(1);
                        o_vld[w]          = 1'b1;
                    end
                end
            end
            KIND_VICTIM: begin
                // Age the whole set so that the chosen way reaches the maximum.
                if (!any_inv) begin
                    for (int w = 0; w < WAYS; w++) begin
                        sum = {1'b0, cur[w]} + {1'b0, diff};
                        o_ctr[w*CW +: CW] = (sum > {1'b0, i_max}) ? i_max : sum[CW-1:0];
                    end
                end
            end
            default: begin
                o_ctr = i_ctr;
            end
        endcase
    end

endmodule
